[rtl/gnm_pkg.sv]
// gnm_pkg: shared types, constants and functions of the gauge needle mapper.
// Holds the control word layout, the microcode table and the slow gauge segment picker.
// No dependencies.
`default_nettype none

package gnm_pkg;

	// Fixed scale points
	localparam logic [15:0] MOTOR_ZERO = 16'd12000;
	localparam logic [11:0] SPEED_MAX  = 12'd2640;
	localparam logic [11:0] RPM_MAX    = 12'd2580;
	localparam logic [7:0]  TRIM_RST   = 8'd100;

	// Configuration register indexes
	localparam logic CFG_TRIM = 1'b0;
	localparam logic CFG_MODE = 1'b1;

	// Datapath widths
	localparam int ACC_W  = 23;
	localparam int RCP_W  = 31;
	localparam int PROD_W = ACC_W + RCP_W;
	localparam int RCP_SH = 33;
	localparam int PC_W   = 4;

	// Constant divide by reciprocal: floor(n/d) = (n * ceil(2^33/d)) >> 33, exact for n < 2^23
	localparam logic [RCP_W-1:0] RCP_5    = RCP_W'(((64'd1 << RCP_SH) + 64'd4) / 64'd5);
	localparam logic [RCP_W-1:0] RCP_7    = RCP_W'(((64'd1 << RCP_SH) + 64'd6) / 64'd7);
	localparam logic [RCP_W-1:0] RCP_10   = RCP_W'(((64'd1 << RCP_SH) + 64'd9) / 64'd10);
	localparam logic [RCP_W-1:0] RCP_100  = RCP_W'(((64'd1 << RCP_SH) + 64'd99) / 64'd100);
	localparam logic [RCP_W-1:0] RCP_400  = RCP_W'(((64'd1 << RCP_SH) + 64'd399) / 64'd400);
	localparam logic [RCP_W-1:0] RCP_1000 = RCP_W'(((64'd1 << RCP_SH) + 64'd999) / 64'd1000);

	typedef enum logic [2:0] {
		DV_NONE, DV_5, DV_7, DV_10, DV_100, DV_400, DV_1000
	} div_t;

	typedef enum logic [2:0] {
		OP_NOP, OP_MUL, OP_SPD, OP_RPM, OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		A_ACC, A_VHI, A_DIFF, A_TOFF
	} asel_t;

	typedef enum logic [2:0] {
		B_TRIM, B_K132, B_K129, B_PMUL, B_SMUL, B_RCP
	} bsel_t;

	typedef enum logic [2:0] {
		DS_100, DS_7, DS_400, DS_PRE, DS_SEG
	} dsel_t;

	typedef enum logic [1:0] {
		C_NEXT, C_GO, C_IN, C_OUT
	} cond_t;

	typedef struct packed {
		op_t             op;
		asel_t           asel;
		bsel_t           bsel;
		dsel_t           dsel;
		cond_t           cond;
		logic [PC_W-1:0] tgt;
	} ctrl_t;

	// Slow gauge segment: base + floor(floor(toff*pmul/pdiv)*smul/sdiv)
	typedef struct packed {
		logic [11:0] toff;
		logic [12:0] pmul;
		div_t        pdiv;
		logic [6:0]  smul;
		div_t        sdiv;
		logic [10:0] base;
	} seg_t;

	function automatic logic [RCP_W-1:0] recip(input div_t d);
		logic [RCP_W-1:0] r;
		unique case (d)
			DV_5:    r = RCP_5;
			DV_7:    r = RCP_7;
			DV_10:   r = RCP_10;
			DV_100:  r = RCP_100;
			DV_400:  r = RCP_400;
			DV_1000: r = RCP_1000;
			default: r = RCP_W'(1);
		endcase
		return r;
	endfunction

	// Microcode: speed, then engine speed, then the slow gauge
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{op: OP_NOP, asel: A_ACC, bsel: B_TRIM, dsel: DS_100, cond: C_NEXT, tgt: '0};
		unique case (pc)
			4'd0: begin
				w.cond = C_IN;
				w.tgt  = PC_W'(1);
			end
			4'd1: begin
				w.op = OP_MUL; w.asel = A_VHI; w.bsel = B_TRIM;
			end
			4'd2: begin
				w.op = OP_MUL; w.bsel = B_RCP; w.dsel = DS_100;
			end
			4'd3: begin
				w.op = OP_MUL; w.bsel = B_K132;
			end
			4'd4: begin
				w.op = OP_MUL; w.bsel = B_RCP; w.dsel = DS_7;
			end
			4'd5: w.op = OP_SPD;
			4'd6: begin
				w.op = OP_MUL; w.asel = A_DIFF; w.bsel = B_K129;
			end
			4'd7: begin
				w.op = OP_MUL; w.bsel = B_RCP; w.dsel = DS_400;
			end
			4'd8: w.op = OP_RPM;
			4'd9: begin
				w.op = OP_MUL; w.asel = A_TOFF; w.bsel = B_PMUL;
			end
			4'd10: begin
				w.op = OP_MUL; w.bsel = B_RCP; w.dsel = DS_PRE;
			end
			4'd11: begin
				w.op = OP_MUL; w.bsel = B_SMUL;
			end
			4'd12: begin
				w.op = OP_MUL; w.bsel = B_RCP; w.dsel = DS_SEG;
			end
			4'd13: begin
				w.op   = OP_OUT;
				w.cond = C_OUT;
				w.tgt  = '0;
			end
			default: begin
				w.cond = C_GO;
				w.tgt  = '0;
			end
		endcase
		return w;
	endfunction

	function automatic seg_t seg_const(input logic [10:0] base);
		seg_t s;
		s = '{toff: '0, pmul: '0, pdiv: DV_NONE, smul: 7'd1, sdiv: DV_NONE, base: base};
		return s;
	endfunction

	function automatic seg_t seg_lin(input logic [11:0] toff, input logic [12:0] pmul,
			input div_t pdiv, input logic [10:0] base);
		seg_t s;
		s = '{toff: toff, pmul: pmul, pdiv: pdiv, smul: 7'd1, sdiv: DV_NONE, base: base};
		return s;
	endfunction

	// Air pressure curve
	function automatic seg_t seg_press(input logic [11:0] t);
		seg_t s;
		if (t < 12'd9)        s = seg_const(11'd0);
		else if (t < 12'd88)  s = seg_lin(t - 12'd9, 13'd466, DV_100, 11'd0);
		else if (t < 12'd124) s = seg_lin(t - 12'd88, 13'd51, DV_10, 11'd368);
		else if (t < 12'd155) s = seg_lin(t - 12'd124, 13'd594, DV_100, 11'd552);
		else if (t < 12'd184) s = seg_lin(t - 12'd155, 13'd635, DV_100, 11'd736);
		else if (t < 12'd200) s = seg_lin(t - 12'd184, 13'd153, DV_10, 11'd920);
		else                  s = seg_const(11'd1104);
		return s;
	endfunction

	function automatic seg_t seg_pick(input logic mode, input logic [1:0] turn,
			input logic [11:0] p1, input logic [11:0] p2, input logic [7:0] soc,
			input logic [11:0] volt, input logic [11:0] fuel);
		seg_t s;
		s = seg_const(11'd0);
		if (!mode) begin
			case (turn)
				2'd0: s = seg_press(p1);
				2'd1: begin
					// state of charge: s = soc*2/5, then s*108/10
					if (soc < 8'd3)
						s = seg_const(11'd0);
					else if (soc >= 8'd253)
						s = seg_const(11'd1080);
					else
						s = '{toff: {4'd0, soc}, pmul: 13'd2, pdiv: DV_5,
							smul: 7'd108, sdiv: DV_10, base: 11'd0};
				end
				2'd2: s = seg_press(p2);
				default: begin
					if (volt < 12'd160)      s = seg_const(11'd0);
					else if (volt < 12'd320) s = seg_lin(volt - 12'd160, 13'd72, DV_10, 11'd0);
					else                     s = seg_const(11'd1152);
				end
			endcase
		end else begin
			case (turn)
				2'd1: begin
					if (fuel < 12'd10)       s = seg_const(11'd0);
					else if (fuel > 12'd180) s = seg_const(11'd1152);
					else if (fuel <= 12'd90) s = seg_lin(fuel - 12'd10, 13'd74, DV_10, 11'd0);
					else                     s = seg_lin(fuel, 13'd65, DV_10, 11'd0);
				end
				2'd3: begin
					if (volt < 12'd180)       s = seg_const(11'd0);
					else if (volt < 12'd240)  s = seg_lin(volt - 12'd180, 13'd6667, DV_1000, 11'd0);
					else if (volt <= 12'd320) s = seg_lin(volt - 12'd240, 13'd10, DV_NONE, 11'd400);
					else                      s = seg_const(11'd1200);
				end
				default: s = seg_const(11'd0);
			endcase
		end
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/gnm_seq.sv]
// gnm_seq: microcode sequencer of the gauge needle mapper.
// Step counter, control word table lookup and conditional jumps; uses gnm_pkg.
`default_nettype none

module gnm_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_free,
	output gnm_pkg::ctrl_t      ctrl
);
	import gnm_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_nxt;

	// Control word of the current step
	assign ctrl = ucode(pc_q);

	// Next step: advance, jump, or hold on a wait condition
	always_comb begin
		unique case (ctrl.cond)
			C_NEXT:  pc_nxt = pc_q + PC_W'(1);
			C_GO:    pc_nxt = ctrl.tgt;
			C_IN:    pc_nxt = in_valid ? ctrl.tgt : pc_q;
			C_OUT:   pc_nxt = out_free ? ctrl.tgt : pc_q;
			default: pc_nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/gauge_needle_mapper.sv]
// Each item runs through the 14-step microprogram, which sends every product and constant
// divide through one shared 23x31 multiplier, and takes a new item only after the result
// register is loaded. A result waits in the output register while the next item runs.
// Reset: asynchronous, active low; trim 100, electric gauge set, pressure one gauge first,
// no result pending.
`default_nettype none

module gauge_needle_mapper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] motor_speed,
	input  wire logic [15:0] vehicle_speed_raw,
	input  wire logic [11:0] pressure_one,
	input  wire logic [11:0] pressure_two,
	input  wire logic [7:0]  soc_raw,
	input  wire logic [11:0] battery_volt,
	input  wire logic [11:0] fuel_level,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      speed_pos,
	output logic [11:0]      rpm_pos,
	output logic [2:0]       slot_gauge,
	output logic [10:0]      slot_pos
);
	import gnm_pkg::*;

	ctrl_t ctrl;
	logic  in_acc;
	logic  out_free;
	logic  out_load;

	logic [7:0]  trim_q;
	logic        mode_q;
	logic [1:0]  turn_q;
	logic        out_valid_q;

	logic [7:0]       vhi_q;
	logic [15:0]      diff_q;
	logic [2:0]       gauge_q;
	seg_t             seg_q;
	logic [ACC_W-1:0] acc_q;
	logic [11:0]      spd_q;
	logic [11:0]      rpm_q;

	logic [11:0] speed_pos_q;
	logic [11:0] rpm_pos_q;
	logic [2:0]  slot_gauge_q;
	logic [10:0] slot_pos_q;

	logic [ACC_W-1:0]  a_op;
	logic [RCP_W-1:0]  b_op;
	div_t              dcode;
	logic              do_shift;
	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0]  mul_res;

	gnm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// Handshakes
	assign in_stall = (ctrl.cond != C_IN);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (ctrl.op == OP_OUT) && out_free;

	// Divisor for a reciprocal step
	always_comb begin
		case (ctrl.dsel)
			DS_100:  dcode = DV_100;
			DS_7:    dcode = DV_7;
			DS_400:  dcode = DV_400;
			DS_PRE:  dcode = seg_q.pdiv;
			DS_SEG:  dcode = seg_q.sdiv;
			default: dcode = DV_NONE;
		endcase
	end

	// Shared multiplier operands
	always_comb begin
		case (ctrl.asel)
			A_VHI:   a_op = ACC_W'(vhi_q);
			A_DIFF:  a_op = ACC_W'(diff_q);
			A_TOFF:  a_op = ACC_W'(seg_q.toff);
			default: a_op = acc_q;
		endcase
		case (ctrl.bsel)
			B_TRIM:  b_op = RCP_W'(trim_q);
			B_K132:  b_op = RCP_W'(132);
			B_K129:  b_op = RCP_W'(129);
			B_PMUL:  b_op = RCP_W'(seg_q.pmul);
			B_SMUL:  b_op = RCP_W'(seg_q.smul);
			default: b_op = recip(dcode);
		endcase
	end

	assign do_shift = (ctrl.bsel == B_RCP) && (dcode != DV_NONE);
	assign prod     = PROD_W'(a_op) * PROD_W'(b_op);
	assign mul_res  = do_shift ? ACC_W'(prod[PROD_W-1:RCP_SH]) : prod[ACC_W-1:0];

	// Control state: configuration, gauge turn, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q      <= TRIM_RST;
			mode_q      <= 1'b0;
			turn_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_TRIM: trim_q <= cfg_wdata;
					CFG_MODE: mode_q <= cfg_wdata[0];
					default:  ;
				endcase
			end
			if (in_acc)
				turn_q <= turn_q + 2'd1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Item capture and working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			vhi_q   <= vehicle_speed_raw[15:8];
			diff_q  <= (motor_speed > MOTOR_ZERO) ? motor_speed - MOTOR_ZERO
			                                      : MOTOR_ZERO - motor_speed;
			gauge_q <= 3'd4 - {1'b0, turn_q};
			seg_q   <= seg_pick(mode_q, turn_q, pressure_one, pressure_two, soc_raw,
				battery_volt, fuel_level);
		end
		case (ctrl.op)
			OP_MUL: acc_q <= mul_res;
			OP_SPD: spd_q <= (acc_q > ACC_W'(SPEED_MAX)) ? SPEED_MAX : acc_q[11:0];
			OP_RPM: rpm_q <= (acc_q > ACC_W'(RPM_MAX)) ? RPM_MAX : acc_q[11:0];
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			speed_pos_q  <= spd_q;
			rpm_pos_q    <= rpm_q;
			slot_gauge_q <= gauge_q;
			slot_pos_q   <= seg_q.base + acc_q[10:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign speed_pos  = speed_pos_q;
	assign rpm_pos    = rpm_pos_q;
	assign slot_gauge = slot_gauge_q;
	assign slot_pos   = slot_pos_q;

endmodule

`default_nettype wire
